// ----- rtl/bounded_list_deque_engine_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bounded list deque engine
// Shorthand for clocked properties that are disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_DEQUE_ENGINE_CORE_MACROS_SVH
`define BOUNDED_LIST_DEQUE_ENGINE_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle
`define BLDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle
`define BLDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bldq_pkg.sv -----
// ----------------------------------------------------------------------------
// bldq_pkg
// Shared types and constants of the bounded list deque engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bldq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 8;
    localparam int POS_W     = 6;
    localparam int MODE_W    = 3;
    localparam int FOUND_W   = 6;
    localparam int STATUS_W  = 3;
    localparam int ECOUNT_W  = 7;

    // Request codes
    typedef enum logic [MODE_W-1:0] {
        MD_PUSH_FRONT = 3'd0,
        MD_PUSH_BACK  = 3'd1,
        MD_POP_FRONT  = 3'd2,
        MD_POP_BACK   = 3'd3,
        MD_INSERT     = 3'd4,
        MD_SEARCH     = 3'd5,
        MD_READ       = 3'd6
    } mode_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_OOB       = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // Per-cell list update
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INSERT,
        SH_REMOVE
    } shift_op_t;

    // Per-cell probe chain update
    typedef enum logic [1:0] {
        PR_HOLD,
        PR_LOAD_MATCH,
        PR_LOAD_INDEX,
        PR_SHIFT
    } probe_op_t;

    typedef struct packed {
        shift_op_t shift_op;
        probe_op_t probe_op;
    } cmd_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/bldq_cell.sv -----
// ----------------------------------------------------------------------------
// bldq_cell
// One list slot plus one probe slot; shifts with its neighbors on command.
// ----------------------------------------------------------------------------
`default_nettype none

module bldq_cell
    import bldq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cmd_t                         cmd,
    input  wire logic [$clog2(DEPTH)-1:0]     at,
    input  wire logic [$clog2(DEPTH+1)-1:0]   cnt,
    input  wire logic [VAL_W-1:0]             key,
    input  wire logic [VAL_W-1:0]             left_entry,
    input  wire logic [VAL_W-1:0]             right_entry,
    input  wire logic [VAL_W-1:0]             right_pdata,
    input  wire logic                         right_phit,
    output logic [VAL_W-1:0]                  entry,
    output logic [VAL_W-1:0]                  pdata,
    output logic                              phit
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
    localparam logic [CW-1:0] MY_IDX_C = CW'(IDX);

    logic [VAL_W-1:0] entry_reg, entry_next;
    logic [VAL_W-1:0] pdata_reg, pdata_next;
    logic             phit_reg, phit_next;

    // Pick the new list slot content
    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.shift_op)
            SH_INSERT:
            begin
                if (MY_IDX == at)
                begin
                    entry_next = key;
                end
                else if (MY_IDX > at)
                begin
                    entry_next = left_entry;
                end
            end
            SH_REMOVE:
            begin
                if (MY_IDX >= at)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Load or advance the probe slot
    always_comb
    begin
        pdata_next = pdata_reg;
        phit_next  = phit_reg;
        unique case (cmd.probe_op)
            PR_LOAD_MATCH:
            begin
                pdata_next = entry_reg;
                phit_next  = (entry_reg == key) && (MY_IDX_C < cnt);
            end
            PR_LOAD_INDEX:
            begin
                pdata_next = entry_reg;
                phit_next  = (MY_IDX == at);
            end
            PR_SHIFT:
            begin
                pdata_next = right_pdata;
                phit_next  = right_phit;
            end
            default:
            begin
                pdata_next = pdata_reg;
                phit_next  = phit_reg;
            end
        endcase
    end

    // Hold the slot contents
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        pdata_reg <= pdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phit_reg <= 1'b0;
        end
        else
        begin
            phit_reg <= phit_next;
        end
    end

    assign entry = entry_reg;
    assign pdata = pdata_reg;
    assign phit  = phit_reg;

endmodule

`default_nettype wire

// ----- rtl/bldq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bldq_ctrl
// Request decoder, entry count, probe scan sequencer and result buffers.
// ----------------------------------------------------------------------------
`default_nettype none

module bldq_ctrl
    import bldq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [MODE_W-1:0]            mode,
    input  wire logic [POS_W-1:0]             position,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [VAL_W-1:0]                  data,
    output logic [FOUND_W-1:0]                found_index,
    output logic [STATUS_W-1:0]               status,
    output logic [ECOUNT_W-1:0]               entry_count,
    output cmd_t                              cmd,
    output logic [$clog2(DEPTH)-1:0]          at,
    output logic [$clog2(DEPTH+1)-1:0]        cnt,
    input  wire logic [VAL_W-1:0]             head_entry,
    input  wire logic [VAL_W-1:0]             head_pdata,
    input  wire logic                         head_phit
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > ECOUNT_W) ? CW : ECOUNT_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    state_t           state_reg, state_next;
    mode_t            kind_reg, kind_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    count_reg, count_next;

    logic             res_valid_reg;
    logic [VAL_W-1:0] res_data_reg;
    logic [FOUND_W-1:0] res_found_reg;
    status_t          res_status_reg;
    logic [ECOUNT_W-1:0] res_count_reg;

    logic             out_valid_reg;
    logic [VAL_W-1:0] out_data_reg;
    logic [FOUND_W-1:0] out_found_reg;
    status_t          out_status_reg;
    logic [ECOUNT_W-1:0] out_count_reg;

    logic             prod;
    logic [VAL_W-1:0] prod_data;
    logic [FOUND_W-1:0] prod_found;
    status_t          prod_status;
    logic [ECOUNT_W-1:0] prod_count;

    logic             in_acc;
    logic             res_move;
    logic [XW-1:0]    pos_x;
    logic [XW-1:0]    cnt_x;
    logic [XW-1:0]    cm1_x;
    logic [XW-1:0]    idx_x;
    logic [XW-1:0]    cnext_x;
    logic [CW-1:0]    cnt_m1;
    logic             full;
    logic             empty;
    logic             last;

    // Take a word only when idle and the result buffer is empty or can drain
    assign res_move = res_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != S_IDLE) || (res_valid_reg && !res_move);
    assign in_acc   = in_valid && !in_stall;

    assign cnt_m1 = count_reg - 1'b1;
    assign pos_x  = XW'(position);
    assign cnt_x  = XW'(count_reg);
    assign cm1_x  = XW'(cnt_m1);
    assign idx_x  = XW'(idx_reg);
    assign full   = (count_reg == FULL_CNT);
    assign empty  = (count_reg == '0);
    assign last   = (idx_x == cm1_x);

    // Decode the request and step the probe scan
    always_comb
    begin
        cmd.shift_op = SH_HOLD;
        cmd.probe_op = PR_HOLD;
        at           = '0;
        prod         = 1'b0;
        prod_data    = '0;
        prod_found   = '0;
        prod_status  = ST_OK;
        count_next   = count_reg;
        state_next   = state_reg;
        idx_next     = idx_reg;
        kind_next    = kind_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (mode_t'(mode)) inside
                        MD_PUSH_FRONT, MD_PUSH_BACK, MD_INSERT:
                        begin
                            prod = 1'b1;
                            if (full)
                            begin
                                prod_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.shift_op = SH_INSERT;
                                count_next   = count_reg + 1'b1;
                                if (mode_t'(mode) == MD_PUSH_FRONT)
                                begin
                                    at = '0;
                                end
                                else if (mode_t'(mode) == MD_PUSH_BACK || pos_x >= cnt_x)
                                begin
                                    at = cnt_x[IW-1:0];
                                end
                                else
                                begin
                                    at = pos_x[IW-1:0];
                                end
                            end
                        end
                        MD_POP_FRONT:
                        begin
                            prod = 1'b1;
                            if (empty)
                            begin
                                prod_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.shift_op = SH_REMOVE;
                                at           = '0;
                                prod_data    = head_entry;
                                count_next   = cnt_m1;
                            end
                        end
                        MD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                prod        = 1'b1;
                                prod_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.probe_op = PR_LOAD_INDEX;
                                at           = cm1_x[IW-1:0];
                                state_next   = S_SCAN;
                                idx_next     = '0;
                                kind_next    = MD_POP_BACK;
                            end
                        end
                        MD_SEARCH:
                        begin
                            if (empty)
                            begin
                                prod        = 1'b1;
                                prod_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.probe_op = PR_LOAD_MATCH;
                                state_next   = S_SCAN;
                                idx_next     = '0;
                                kind_next    = MD_SEARCH;
                            end
                        end
                        MD_READ:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                prod        = 1'b1;
                                prod_status = ST_OOB;
                            end
                            else
                            begin
                                cmd.probe_op = PR_LOAD_INDEX;
                                at           = pos_x[IW-1:0];
                                state_next   = S_SCAN;
                                idx_next     = '0;
                                kind_next    = MD_READ;
                            end
                        end
                        default:
                        begin
                            prod = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (head_phit)
                begin
                    prod       = 1'b1;
                    state_next = S_IDLE;
                    if (kind_reg == MD_SEARCH)
                    begin
                        prod_found = idx_x[FOUND_W-1:0];
                    end
                    else
                    begin
                        prod_data = head_pdata;
                    end
                    if (kind_reg == MD_POP_BACK)
                    begin
                        count_next = cnt_m1;
                    end
                end
                else if (kind_reg == MD_SEARCH && last)
                begin
                    prod        = 1'b1;
                    prod_status = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.probe_op = PR_SHIFT;
                    idx_next     = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        cnext_x    = XW'(count_next);
        prod_count = cnext_x[ECOUNT_W-1:0];
    end

    // Hold sequencer state and the entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= MD_SEARCH;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    // Result buffer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (prod)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_move)
            begin
                res_valid_reg <= 1'b0;
            end

            if (res_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod)
        begin
            res_data_reg   <= prod_data;
            res_found_reg  <= prod_found;
            res_status_reg <= prod_status;
            res_count_reg  <= prod_count;
        end
        if (res_move)
        begin
            out_data_reg   <= res_data_reg;
            out_found_reg  <= res_found_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= res_count_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data        = out_data_reg;
    assign found_index = out_found_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;
    assign cnt         = count_reg;

endmodule

`default_nettype wire

// ----- rtl/bounded_list_deque_engine_core.sv -----
// ----------------------------------------------------------------------------
// bounded_list_deque_engine_core
// Ordered byte list with push, pop, insert, search and read over a cell row.
//
//   channel  direction  handshake            payload
//   in       in         in_valid / in_stall  mode, value, position
//   out      out        out_valid / out_stall data, found_index, status,
//                                            entry_count
//
// Push, insert, pop front and invalid requests need no scan; a new word can
// be taken every cycle unless a stalled result fills the buffer. Search, read
// and pop back load the probe chain and shift it toward cell 0 one slot a cycle.
// Reset clears the count and control; list slots need no clearing.
// An output stall holds the result; one more result can wait in a buffer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_list_deque_engine_core_macros.svh"

module bounded_list_deque_engine_core
    import bldq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [VAL_W-1:0]      value,
    input  wire logic [POS_W-1:0]      position,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [VAL_W-1:0]           data,
    output logic [FOUND_W-1:0]         found_index,
    output logic [STATUS_W-1:0]        status,
    output logic [ECOUNT_W-1:0]        entry_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [ECOUNT_W-1:0] DEPTH_LO = ECOUNT_W'(DEPTH);

    cmd_t              cmd;
    logic [IW-1:0]     at;
    logic [CW-1:0]     cnt;
    logic [VAL_W-1:0]  entry_w [DEPTH];
    logic [VAL_W-1:0]  pdata_w [DEPTH];
    logic              phit_w  [DEPTH];

    // Sequencer and result buffering
    bldq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data        (data),
        .found_index (found_index),
        .status      (status),
        .entry_count (entry_count),
        .cmd         (cmd),
        .at          (at),
        .cnt         (cnt),
        .head_entry  (entry_w[0]),
        .head_pdata  (pdata_w[0]),
        .head_phit   (phit_w[0])
    );

    // Row of list cells, front at cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VAL_W-1:0] left_entry;
        logic [VAL_W-1:0] right_entry;
        logic [VAL_W-1:0] right_pdata;
        logic             right_phit;

        if (i == 0)
        begin : g_first
            assign left_entry = '0;
        end
        else
        begin : g_mid_l
            assign left_entry = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = '0;
            assign right_pdata = '0;
            assign right_phit  = 1'b0;
        end
        else
        begin : g_mid_r
            assign right_entry = entry_w[i+1];
            assign right_pdata = pdata_w[i+1];
            assign right_phit  = phit_w[i+1];
        end

        bldq_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .at          (at),
            .cnt         (cnt),
            .key         (value),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .right_pdata (right_pdata),
            .right_phit  (right_phit),
            .entry       (entry_w[i]),
            .pdata       (pdata_w[i]),
            .phit        (phit_w[i])
        );
    end

    // Result field consistency
    `BLDQ_ASSERT_NOW(a_empty_clean, out_valid && status == ST_EMPTY, data == '0 && entry_count == '0, "empty pop carries data or entries")
    `BLDQ_ASSERT_NOW(a_full_count, out_valid && status == ST_FULL, entry_count == DEPTH_LO, "full drop with count below depth")
    `BLDQ_ASSERT_NOW(a_miss_clean, out_valid && (status == ST_NOT_FOUND || status == ST_OOB), data == '0 && found_index == '0, "failed lookup carries data")

endmodule

`default_nettype wire
